// ===== rtl/palhsv_pkg.sv =====
// Package for the palette HSV hue/shade recolor pipeline.
// Holds shared constants, the channel widen/narrow helpers and the divider step.
// No dependencies.
package palhsv_pkg;

	localparam int unsigned HUE_COUNT_DEF = 16;
	localparam int unsigned LATENCY       = 10;

	localparam logic [7:0] HUE_BASE_G = 8'd85;
	localparam logic [7:0] HUE_BASE_B = 8'd171;
	localparam logic [7:0] SECTOR_W   = 8'd43;

	typedef enum logic [0:0] {
		REG_HUE   = 1'b0,
		REG_SHADE = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [15:0] rem;
		logic [1:0]  qbits;
	} div2_t;

	// 5-bit channel to 8 bits, c*255/31 by reciprocal (exact for all 32 codes).
	function automatic logic [7:0] widen_f(input logic [4:0] c);
		logic [28:0] prod;
		prod = 29'({c, 8'b0} - {8'b0, c}) * 29'd33826;
		return prod[27:20];
	endfunction

	// 8-bit channel to 5 bits, c*31/255 via the x/255 identity.
	function automatic logic [4:0] narrow_f(input logic [7:0] c);
		logic [12:0] x;
		logic [13:0] y;
		x = 13'({c, 5'b0}) - 13'(c);
		y = 14'(x) + 14'(x[12:8]) + 14'd1;
		return y[12:8];
	endfunction

	// Two restoring quotient bits, k and k-1.
	function automatic div2_t div2_f(input logic [15:0] rem, input logic [7:0] den,
			input int unsigned k);
		logic [23:0] r;
		logic [23:0] sh;
		div2_t       o;
		r  = {8'b0, rem};
		sh = {16'b0, den} << k;
		o.qbits = 2'b00;
		if (r >= sh) begin
			r = r - sh;
			o.qbits[1] = 1'b1;
		end
		sh = {16'b0, den} << (k - 1);
		if (r >= sh) begin
			r = r - sh;
			o.qbits[0] = 1'b1;
		end
		o.rem = r[15:0];
		return o;
	endfunction

endpackage

// ===== rtl/palette_hsv_hue_shade_adjust_top.sv =====
// The start beat is registered through stages s1, dv, s6 to s9 and the done register; throughput one colour per cycle.
// busy stays low: a new colour may start every cycle, results are never held off.
// The depth is set by the 8-bit quotient divider (two bits per stage) and the HSV->RGB multiplies.
// arst_n clears the valid bits and both settings to zero (colours pass through unchanged).
// Depends on palhsv_pkg.
module palette_hsv_hue_shade_adjust_top
	import palhsv_pkg::*;
#(
	parameter int unsigned HUE_COUNT = HUE_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_addr,
	input  logic [3:0]  cfg_wdata,
	input  logic [14:0] color_in,
	input  logic [3:0]  entry_index,
	input  logic        last_entry,
	output logic        done,
	output logic [14:0] color_out,
	output logic [3:0]  entry_out,
	output logic        last_out
);

	localparam int unsigned HUE_STEP = 256 / HUE_COUNT;
	localparam int unsigned NDIV     = 4;

	logic [3:0]        hue_q;
	logic signed [3:0] shade_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hue_q   <= '0;
			shade_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_addr))
				REG_HUE:   hue_q   <= cfg_wdata;
				REG_SHADE: shade_q <= cfg_wdata;
				default:   ;
			endcase
		end
	end

	assign busy = 1'b0;

	// stage 1: widen, min/max, divider operands
	logic [7:0] r8, g8, b8, hi, lo, d8, hdiff;
	logic [7:0] hbase;
	logic       hneg;
	logic [8:0] dx;

	always_comb begin
		r8 = widen_f(color_in[4:0]);
		g8 = widen_f(color_in[9:5]);
		b8 = widen_f(color_in[14:10]);
		hi = r8;
		lo = r8;
		if (g8 > hi) hi = g8;
		if (b8 > hi) hi = b8;
		if (g8 < lo) lo = g8;
		if (b8 < lo) lo = b8;
		d8 = hi - lo;
		if (hi == r8) begin
			hbase = 8'd0;
			dx    = {1'b0, g8} - {1'b0, b8};
		end else if (hi == g8) begin
			hbase = HUE_BASE_G;
			dx    = {1'b0, b8} - {1'b0, r8};
		end else begin
			hbase = HUE_BASE_B;
			dx    = {1'b0, r8} - {1'b0, g8};
		end
		hneg  = dx[8];
		hdiff = hneg ? 8'(-dx) : dx[7:0];
	end

	logic        vld_s1, byp_s1, grey_s1, hneg_s1, last_s1;
	logic [7:0]  v_s1, den_s1, hbase_s1;
	logic [15:0] remh_s1, rems_s1;
	logic [14:0] col_s1;
	logic [3:0]  ent_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else         vld_s1 <= start;
	end

	always_ff @(posedge clk) begin
		byp_s1   <= (hue_q == '0) && (shade_q == '0);
		grey_s1  <= (d8 == 8'd0);
		hneg_s1  <= hneg;
		v_s1     <= hi;
		den_s1   <= d8;
		hbase_s1 <= hbase;
		remh_s1  <= 16'(hdiff) * 16'd43;
		rems_s1  <= {d8, 8'b0} - 16'(d8);
		col_s1   <= color_in;
		ent_s1   <= entry_index;
		last_s1  <= last_entry;
	end

	// stages 2..5: two quotient bits per stage for hue (over d) and saturation (over v)
	logic        vld_dv  [NDIV];
	logic        byp_dv  [NDIV];
	logic        grey_dv [NDIV];
	logic        hneg_dv [NDIV];
	logic        last_dv [NDIV];
	logic [7:0]  v_dv    [NDIV];
	logic [7:0]  den_dv  [NDIV];
	logic [7:0]  hbase_dv[NDIV];
	logic [15:0] remh_dv [NDIV];
	logic [15:0] rems_dv [NDIV];
	logic [7:0]  qh_dv   [NDIV];
	logic [7:0]  qs_dv   [NDIV];
	logic [14:0] col_dv  [NDIV];
	logic [3:0]  ent_dv  [NDIV];

	div2_t       sh_n [NDIV];
	div2_t       ss_n [NDIV];

	always_comb begin
		for (int j = 0; j < NDIV; j++) begin
			if (j == 0) begin
				sh_n[j] = div2_f(remh_s1, den_s1, 7);
				ss_n[j] = div2_f(rems_s1, v_s1, 7);
			end else begin
				sh_n[j] = div2_f(remh_dv[j-1], den_dv[j-1], 7 - 2 * j);
				ss_n[j] = div2_f(rems_dv[j-1], v_dv[j-1], 7 - 2 * j);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < NDIV; j++) vld_dv[j] <= 1'b0;
		end else begin
			vld_dv[0] <= vld_s1;
			for (int j = 1; j < NDIV; j++) vld_dv[j] <= vld_dv[j-1];
		end
	end

	always_ff @(posedge clk) begin
		byp_dv[0]   <= byp_s1;
		grey_dv[0]  <= grey_s1;
		hneg_dv[0]  <= hneg_s1;
		last_dv[0]  <= last_s1;
		v_dv[0]     <= v_s1;
		den_dv[0]   <= den_s1;
		hbase_dv[0] <= hbase_s1;
		col_dv[0]   <= col_s1;
		ent_dv[0]   <= ent_s1;
		remh_dv[0]  <= sh_n[0].rem;
		rems_dv[0]  <= ss_n[0].rem;
		qh_dv[0]    <= {sh_n[0].qbits, 6'b0};
		qs_dv[0]    <= {ss_n[0].qbits, 6'b0};
		for (int j = 1; j < NDIV; j++) begin
			byp_dv[j]   <= byp_dv[j-1];
			grey_dv[j]  <= grey_dv[j-1];
			hneg_dv[j]  <= hneg_dv[j-1];
			last_dv[j]  <= last_dv[j-1];
			v_dv[j]     <= v_dv[j-1];
			den_dv[j]   <= den_dv[j-1];
			hbase_dv[j] <= hbase_dv[j-1];
			col_dv[j]   <= col_dv[j-1];
			ent_dv[j]   <= ent_dv[j-1];
			remh_dv[j]  <= sh_n[j].rem;
			rems_dv[j]  <= ss_n[j].rem;
			qh_dv[j]    <= qh_dv[j-1] | (8'(sh_n[j].qbits) << (6 - 2 * j));
			qs_dv[j]    <= qs_dv[j-1] | (8'(ss_n[j].qbits) << (6 - 2 * j));
		end
	end

	// stage 6: rotate hue, shade value and saturation
	localparam int L = NDIV - 1;

	logic [7:0]        hoff, hrot, hue_add;
	logic signed [9:0] v_sum, s_sum;
	logic [7:0]        v_adj, s_adj;

	always_comb begin
		hue_add = 8'(16'(hue_q) * 16'(HUE_STEP));
		if (grey_dv[L]) hoff = 8'd0;
		else            hoff = hbase_dv[L] + (hneg_dv[L] ? 8'(-qh_dv[L]) : qh_dv[L]);
		hrot  = hoff + hue_add;
		v_sum = $signed({2'b0, v_dv[L]}) + 10'(shade_q) * 10'sd24;
		s_sum = $signed({2'b0, grey_dv[L] ? 8'd0 : qs_dv[L]}) + 10'(shade_q) * 10'sd8;
		if (v_sum < 0)            v_adj = 8'd0;
		else if (v_sum > 10'sd255) v_adj = 8'd255;
		else                      v_adj = v_sum[7:0];
		if (s_sum < 0)            s_adj = 8'd0;
		else if (s_sum > 10'sd255) s_adj = 8'd255;
		else                      s_adj = s_sum[7:0];
	end

	logic        vld_s6, byp_s6, last_s6;
	logic [7:0]  h_s6, s_s6, v_s6;
	logic [14:0] col_s6;
	logic [3:0]  ent_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s6 <= 1'b0;
		else         vld_s6 <= vld_dv[L];
	end

	always_ff @(posedge clk) begin
		byp_s6  <= byp_dv[L];
		last_s6 <= last_dv[L];
		h_s6    <= hrot;
		s_s6    <= s_adj;
		v_s6    <= v_adj;
		col_s6  <= col_dv[L];
		ent_s6  <= ent_dv[L];
	end

	// stage 7: sector and position within it
	logic [2:0] sector;
	logic [7:0] sec_base;
	logic [7:0] frac;

	always_comb begin
		priority if (h_s6 >= 8'd215) sector = 3'd5;
		else if (h_s6 >= 8'd172)     sector = 3'd4;
		else if (h_s6 >= 8'd129)     sector = 3'd3;
		else if (h_s6 >= 8'd86)      sector = 3'd2;
		else if (h_s6 >= SECTOR_W)   sector = 3'd1;
		else                         sector = 3'd0;
		sec_base = 8'(11'(sector) * 11'(SECTOR_W));
		frac     = h_s6 - sec_base;
	end

	logic        vld_s7, byp_s7, last_s7;
	logic [2:0]  sec_s7;
	logic [7:0]  rem_s7, s_s7, v_s7;
	logic [14:0] col_s7;
	logic [3:0]  ent_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s7 <= 1'b0;
		else         vld_s7 <= vld_s6;
	end

	always_ff @(posedge clk) begin
		byp_s7  <= byp_s6;
		last_s7 <= last_s6;
		sec_s7  <= sector;
		rem_s7  <= 8'({frac, 2'b0} + {1'b0, frac, 1'b0});
		s_s7    <= s_s6;
		v_s7    <= v_s6;
		col_s7  <= col_s6;
		ent_s7  <= ent_s6;
	end

	// stage 8: first products
	logic [15:0] pa, pb, pp;

	always_comb begin
		pa = 16'(s_s7) * 16'(rem_s7);
		pb = 16'(s_s7) * 16'(8'd255 - rem_s7);
		pp = 16'(v_s7) * 16'(8'd255 - s_s7);
	end

	logic        vld_s8, byp_s8, last_s8, sz_s8;
	logic [2:0]  sec_s8;
	logic [7:0]  a_s8, b_s8, p_s8, v_s8;
	logic [14:0] col_s8;
	logic [3:0]  ent_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s8 <= 1'b0;
		else         vld_s8 <= vld_s7;
	end

	always_ff @(posedge clk) begin
		byp_s8  <= byp_s7;
		last_s8 <= last_s7;
		sz_s8   <= (s_s7 == 8'd0);
		sec_s8  <= sec_s7;
		a_s8    <= pa[15:8];
		b_s8    <= pb[15:8];
		p_s8    <= pp[15:8];
		v_s8    <= v_s7;
		col_s8  <= col_s7;
		ent_s8  <= ent_s7;
	end

	// stage 9: q and t
	logic [15:0] pq, pt;

	always_comb begin
		pq = 16'(v_s8) * 16'(8'd255 - a_s8);
		pt = 16'(v_s8) * 16'(8'd255 - b_s8);
	end

	logic        vld_s9, byp_s9, last_s9, sz_s9;
	logic [2:0]  sec_s9;
	logic [7:0]  p_s9, q_s9, t_s9, v_s9;
	logic [14:0] col_s9;
	logic [3:0]  ent_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s9 <= 1'b0;
		else         vld_s9 <= vld_s8;
	end

	always_ff @(posedge clk) begin
		byp_s9  <= byp_s8;
		last_s9 <= last_s8;
		sz_s9   <= sz_s8;
		sec_s9  <= sec_s8;
		p_s9    <= p_s8;
		q_s9    <= pq[15:8];
		t_s9    <= pt[15:8];
		v_s9    <= v_s8;
		col_s9  <= col_s8;
		ent_s9  <= ent_s8;
	end

	// stage 10: pick channels by sector, narrow, output register
	logic [7:0]  ro, go, bo;
	logic [14:0] col_new;

	always_comb begin
		if (sz_s9) begin
			ro = v_s9; go = v_s9; bo = v_s9;
		end else begin
			unique case (sec_s9)
				3'd0:    begin ro = v_s9; go = t_s9; bo = p_s9; end
				3'd1:    begin ro = q_s9; go = v_s9; bo = p_s9; end
				3'd2:    begin ro = p_s9; go = v_s9; bo = t_s9; end
				3'd3:    begin ro = p_s9; go = q_s9; bo = v_s9; end
				3'd4:    begin ro = t_s9; go = p_s9; bo = v_s9; end
				default: begin ro = v_s9; go = p_s9; bo = q_s9; end
			endcase
		end
		col_new = {narrow_f(bo), narrow_f(go), narrow_f(ro)};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else         done <= vld_s9;
	end

	always_ff @(posedge clk) begin
		color_out <= byp_s9 ? col_s9 : col_new;
		entry_out <= ent_s9;
		last_out  <= last_s9;
	end

endmodule

// ===== rtl/palhsv_checker.sv =====
// Port-level checker for the palette recolor pipeline, bound to the top level.
// Depends on palhsv_pkg for the pipeline latency.
module palhsv_checker
	import palhsv_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       done,
	input logic [3:0] entry_index,
	input logic       last_entry,
	input logic [3:0] entry_out,
	input logic       last_out
);

	logic [3:0] warm_q;

	// count cycles since reset so history reaches back past the pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)                      warm_q <= '0;
		else if (warm_q != 4'(LATENCY))   warm_q <= warm_q + 4'd1;
	end

	a_no_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	a_done_lat: assert property (@(posedge clk) disable iff (!arst_n)
		(warm_q == 4'(LATENCY)) |-> (done == $past(start, LATENCY)))
		else $error("done does not follow start by the pipeline latency");

	a_entry_echo: assert property (@(posedge clk) disable iff (!arst_n)
		(done && warm_q == 4'(LATENCY)) |-> (entry_out == $past(entry_index, LATENCY)))
		else $error("entry index out of order");

	a_last_echo: assert property (@(posedge clk) disable iff (!arst_n)
		(done && warm_q == 4'(LATENCY)) |-> (last_out == $past(last_entry, LATENCY)))
		else $error("last flag out of order");

endmodule

bind palette_hsv_hue_shade_adjust_top palhsv_checker u_palhsv_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.entry_index (entry_index),
	.last_entry  (last_entry),
	.entry_out   (entry_out),
	.last_out    (last_out)
);

// ===== test/tb.sv =====
// Testbench for palette_hsv_hue_shade_adjust_top: RGB555 hue rotate and shade adjust.
// Predicts each recolored entry in SystemVerilog and checks every done beat in order.
// Depends on palhsv_pkg and the top level RTL.
`timescale 1ns / 100ps

module tb;
	import palhsv_pkg::*;

	localparam int HUE_STEP_SIZE = 256 / HUE_COUNT_DEF;
	localparam int CYCLE_LIMIT   = 200000;

	typedef struct packed {
		logic [14:0] color;
		logic [3:0]  entry;
		logic        last;
	} swatch_t;

	typedef struct packed {
		logic        is_cfg;
		cfg_reg_t    addr;
		logic [3:0]  data;
		logic        quiet;
		swatch_t     sw;
	} job_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        cfg_we;
	logic [0:0]  cfg_addr;
	logic [3:0]  cfg_wdata;
	logic [14:0] color_in;
	logic [3:0]  entry_index;
	logic        last_entry;
	logic        done;
	logic [14:0] color_out;
	logic [3:0]  entry_out;
	logic        last_out;

	job_t    job_q[$];
	swatch_t recolor_q[$];
	int      err_count;
	int      cycles;
	int      gap_left;
	int      drain_wait;
	logic [3:0] hue_reg;
	logic signed [3:0] shade_reg;

	palette_hsv_hue_shade_adjust_top uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
		.color_in(color_in), .entry_index(entry_index), .last_entry(last_entry),
		.done(done), .color_out(color_out), .entry_out(entry_out), .last_out(last_out)
	);

	always #4 clk = ~clk;

	function automatic int clamp255(input int x);
		if (x < 0) return 0;
		if (x > 255) return 255;
		return x;
	endfunction

	function automatic logic [14:0] recolor(input logic [14:0] c, input logic [3:0] hs,
			input logic signed [3:0] sh);
		int r, g, b, hi, lo, d, h, s, v, hv, sec, rm, p, q, t;
		if (hs == 0 && sh == 0) return c;
		r = int'(c[4:0]) * 255 / 31;
		g = int'(c[9:5]) * 255 / 31;
		b = int'(c[14:10]) * 255 / 31;
		hi = r; lo = r;
		if (g > hi) hi = g;
		if (b > hi) hi = b;
		if (g < lo) lo = g;
		if (b < lo) lo = b;
		v = hi;
		d = hi - lo;
		if (hi == 0 || d == 0) begin
			s = 0;
			h = 0;
		end else begin
			s = d * 255 / hi;
			if (hi == r) hv = 43 * (g - b) / d;
			else if (hi == g) hv = 85 + 43 * (b - r) / d;
			else hv = 171 + 43 * (r - g) / d;
			h = hv & 255;
		end
		h = (h + int'(hs) * HUE_STEP_SIZE) & 255;
		v = clamp255(v + int'(sh) * 24);
		s = clamp255(s + int'(sh) * 8);
		if (s == 0) begin
			r = v; g = v; b = v;
		end else begin
			sec = h / 43;
			rm = (h - sec * 43) * 6;
			p = (v * (255 - s)) >>> 8;
			q = (v * (255 - ((s * rm) >>> 8))) >>> 8;
			t = (v * (255 - ((s * (255 - rm)) >>> 8))) >>> 8;
			case (sec)
				0: begin r = v; g = t; b = p; end
				1: begin r = q; g = v; b = p; end
				2: begin r = p; g = v; b = t; end
				3: begin r = p; g = q; b = v; end
				4: begin r = t; g = p; b = v; end
				default: begin r = v; g = p; b = q; end
			endcase
		end
		return {5'(b * 31 / 255), 5'(g * 31 / 255), 5'(r * 31 / 255)};
	endfunction

	task automatic report(input string what, input int got, input int want);
		$display("ERROR t=%0t %s: got %0h want %0h", $time, what, got, want);
		err_count++;
	endtask

	task automatic push_color(input logic [14:0] c, input logic quiet);
		job_t j;
		j = '0;
		j.quiet = quiet;
		j.sw.color = c;
		j.sw.entry = 4'($urandom);
		j.sw.last = 1'($urandom);
		job_q.push_back(j);
	endtask

	task automatic push_cfg(input cfg_reg_t a, input logic [3:0] d);
		job_t j;
		j = '0;
		j.is_cfg = 1'b1;
		j.addr = a;
		j.data = d;
		job_q.push_back(j);
	endtask

	// Driver: config writes wait for the pipe to drain, non-quiet colors go out with random gaps.
	always @(negedge clk) begin
		logic go;
		logic wr;
		go = 1'b0;
		wr = 1'b0;
		if (arst_n) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
			end else if (job_q.size() > 0) begin
				if (job_q[0].is_cfg) begin
					if (recolor_q.size() == 0) begin
						if (drain_wait < LATENCY + 2) begin
							drain_wait <= drain_wait + 1;
						end else begin
							drain_wait <= 0;
							wr = 1'b1;
							cfg_addr <= job_q[0].addr;
							cfg_wdata <= job_q[0].data;
							if (job_q[0].addr == REG_HUE) hue_reg = job_q[0].data;
							else shade_reg = job_q[0].data;
							void'(job_q.pop_front());
						end
					end
				end else if (!busy) begin
					go = 1'b1;
					color_in <= job_q[0].sw.color;
					entry_index <= job_q[0].sw.entry;
					last_entry <= job_q[0].sw.last;
					recolor_q.push_back('{recolor(job_q[0].sw.color, hue_reg, shade_reg),
						job_q[0].sw.entry, job_q[0].sw.last});
					if (!job_q[0].quiet && $urandom_range(0, 5) == 0)
						gap_left <= $urandom_range(1, 7);
					void'(job_q.pop_front());
				end
			end
		end
		start <= go;
		cfg_we <= wr;
	end

	// Monitor: check each done beat against the oldest expectation.
	always @(posedge clk) begin
		swatch_t w;
		cycles <= cycles + 1;
		if (arst_n && done) begin
			if (recolor_q.size() == 0) begin
				report("unexpected beat", color_out, 0);
			end else begin
				w = recolor_q.pop_front();
				if (color_out !== w.color) report("color_out", color_out, w.color);
				if (entry_out !== w.entry) report("entry_out", entry_out, w.entry);
				if (last_out !== w.last) report("last_out", last_out, w.last);
			end
		end
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		logic [4:0] cv[5];
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = REG_HUE;
		cfg_wdata = '0;
		color_in = '0;
		entry_index = '0;
		last_entry = 1'b0;
		err_count = 0;
		cycles = 0;
		gap_left = 0;
		drain_wait = 0;
		hue_reg = '0;
		shade_reg = '0;
		cv = '{5'd0, 5'd31, 5'd16, 5'd1, 5'd30};

		// Directed: neutral pass-through, then extremes, greys and every hue sector.
		push_color(15'h0000, 1'b0);
		push_color(15'h7FFF, 1'b0);
		push_color(15'h2AAA, 1'b0);
		push_cfg(REG_HUE, 4'd15);
		push_cfg(REG_SHADE, 4'b1000);
		push_color(15'h0000, 1'b0);
		push_color(15'h7FFF, 1'b0);
		push_color(15'h4210, 1'b0);
		push_color({5'd0, 5'd0, 5'd31}, 1'b0);
		push_color({5'd0, 5'd31, 5'd0}, 1'b0);
		push_color({5'd31, 5'd0, 5'd0}, 1'b0);
		push_color({5'd31, 5'd0, 5'd31}, 1'b0);
		push_cfg(REG_SHADE, 4'd7);
		push_cfg(REG_HUE, 4'd0);
		push_color({5'd31, 5'd31, 5'd0}, 1'b0);
		push_color({5'd0, 5'd31, 5'd31}, 1'b0);
		push_color({5'd3, 5'd0, 5'd31}, 1'b0);
		push_color({5'd31, 5'd1, 5'd0}, 1'b0);
		push_color(15'h0421, 1'b0);

		// Random phases over a spread of settings.
		for (int ph = 0; ph < 12; ph++) begin
			push_cfg(REG_HUE, 4'($urandom));
			push_cfg(REG_SHADE, 4'($urandom));
			for (int i = 0; i < 60; i++) begin
				if ($urandom_range(0, 3) == 0)
					push_color({cv[$urandom_range(0, 4)], cv[$urandom_range(0, 4)],
						cv[$urandom_range(0, 4)]}, ph >= 10);
				else
					push_color(15'($urandom), ph >= 10);
			end
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		wait (job_q.size() == 0 && recolor_q.size() == 0);
		repeat (LATENCY + 5) @(posedge clk);
		if (err_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule

// ===== sim.f =====
rtl/palhsv_pkg.sv
rtl/palette_hsv_hue_shade_adjust_top.sv
rtl/palhsv_checker.sv
test/tb.sv
